// ===== hdl/bsmm_pkg.sv =====
// Package for the bank-switched memory mapper: request and response payloads,
// function codes, memory command structs and the response source select.
// No dependencies.
package bsmm_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  // Low two bits of a card switch address.
  localparam logic [1:0] SW_READ_CARD = 2'd0;
  localparam logic [1:0] SW_ROM_WE    = 2'd1;
  localparam logic [1:0] SW_ROM_PROT  = 2'd2;
  localparam logic [1:0] SW_CARD_WE   = 2'd3;

  localparam int RAM_ADDR_W = 16;
  localparam int ROM_ADDR_W = 14;

  localparam logic [7:0] STROBE_BIT = 8'h80;
  localparam logic [7:0] KEY_MASK   = 8'h7F;
  localparam logic [7:0] IO_PAGE    = 8'hC0;
  localparam logic [3:0] CARD_LOW   = 4'hD;
  localparam logic [3:0] BANK_ONE   = 4'hC;
  localparam logic [3:0] SWITCH_ROW = 4'h8;
  localparam logic [7:0] KBD_LOW    = 8'h00;
  localparam logic [7:0] STROBE_LOW = 8'h10;
  localparam logic [7:0] SLOT_LOW   = 8'h90;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [6:0]  key_code;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       slot_io;
  } rsp_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_RAM,
    SRC_ROM
  } src_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [RAM_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ROM_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } rom_cmd_t;

  // Response stage: what to return once the memory read data is out.
  typedef struct packed {
    src_t       src;
    logic [7:0] const_data;
    logic       slot_io;
  } stage_t;

endpackage

// ===== hdl/bsmm_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// The payload type is supplied where the channel is instantiated.
interface bsmm_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/bank_switched_memory_mapper_top.sv =====
// 64K memory map with 48K main RAM, a 16K ROM and a 16K bank-switched RAM card.
// Depends on bsmm_pkg, bsmm_chan_if, bsmm_ram and bsmm_ctrl.
//
// One request transfer is taken per clock while the response side keeps up,
// and its response comes out on the next cycle, set by the registered read
// data of the synchronous RAM and ROM; a stalled response holds its read data
// while the next request waits. Main RAM and all card RAM share one 64K x 8
// memory (bank one sits in the C000-CFFF hole), and the ROM is a separate 16K x 8
// memory. After reset a clearing pass writes the power-on pattern into the
// RAM and all ones into the ROM; no request is accepted until it finishes.
module bank_switched_memory_mapper_top (
  input  logic        clk,
  input  logic        rst,
  bsmm_chan_if.sink   req,
  bsmm_chan_if.source rsp
);
  import bsmm_pkg::*;

  stage_t     stage;
  ram_cmd_t   ram_cmd;
  rom_cmd_t   rom_cmd;
  logic [7:0] ram_q;
  logic [7:0] rom_q;
  logic [7:0] read_data;

  bsmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .stage     (stage),
    .ram_cmd   (ram_cmd),
    .rom_cmd   (rom_cmd)
  );

  bsmm_ram #(.ADDR_W(RAM_ADDR_W), .DATA_W(8)) u_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .re    (ram_cmd.re),
    .addr  (ram_cmd.addr),
    .wdata (ram_cmd.wdata),
    .rdata (ram_q)
  );

  bsmm_ram #(.ADDR_W(ROM_ADDR_W), .DATA_W(8)) u_rom (
    .clk   (clk),
    .we    (rom_cmd.we),
    .re    (rom_cmd.re),
    .addr  (rom_cmd.addr),
    .wdata (rom_cmd.wdata),
    .rdata (rom_q)
  );

  always_comb begin
    unique case (stage.src)
      SRC_RAM: read_data = ram_q;
      SRC_ROM: read_data = rom_q;
      default: read_data = stage.const_data;
    endcase
  end

  assign rsp.payload = '{read_data: read_data, slot_io: stage.slot_io};
endmodule

// ===== hdl/bsmm_ram.sv =====
// Synchronous single-port memory with registered read data.
// Used for the unified RAM and for the ROM store. No dependencies.
module bsmm_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// ===== hdl/bsmm_ctrl.sv =====
// Address decode, card switches, keyboard latch, clearing pass and response stage.
// Depends on bsmm_pkg and bsmm_chan_if.
module bsmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  bsmm_chan_if.sink           req,
  input  logic                out_ready,
  output logic                out_valid,
  output bsmm_pkg::stage_t    stage,
  output bsmm_pkg::ram_cmd_t  ram_cmd,
  output bsmm_pkg::rom_cmd_t  rom_cmd
);
  import bsmm_pkg::*;

  logic       read_from_card, read_from_card_next;
  logic       second_bank, second_bank_next;
  logic       card_locked, card_locked_next;
  logic       prewrite_armed, prewrite_armed_next;
  logic [7:0] key_latch, key_latch_next;
  logic       clr_busy;
  logic [RAM_ADDR_W-1:0] clr_addr;
  stage_t     stage_next;
  logic       accept;
  logic       is_rw, is_write, is_switch;
  logic [15:0] addr;
  logic [7:0]  low;
  logic [RAM_ADDR_W-1:0] card_addr;

  assign req.ready = !clr_busy && (!out_valid || out_ready);
  assign accept    = req.valid && req.ready;

  assign addr     = req.payload.address;
  assign low      = addr[7:0];
  assign is_rw    = (req.payload.func == FUNC_READ) || (req.payload.func == FUNC_WRITE);
  assign is_write = (req.payload.func == FUNC_WRITE);
  assign is_switch = is_rw && (addr[15:8] == IO_PAGE) && (low[7:4] == SWITCH_ROW);

  // Bank one lives at C000-CFFF of the unified RAM, bank two and the high RAM
  // at their own addresses.
  always_comb begin
    card_addr = addr;
    if (addr[15:12] == CARD_LOW && !second_bank) begin
      card_addr = {BANK_ONE, addr[11:0]};
    end
  end

  always_comb begin
    read_from_card_next  = read_from_card;
    second_bank_next     = second_bank;
    card_locked_next     = card_locked;
    prewrite_armed_next  = prewrite_armed;
    key_latch_next       = key_latch;
    stage_next           = '{src: SRC_CONST, const_data: 8'h00, slot_io: 1'b0};
    ram_cmd = '{we: 1'b0, re: 1'b0, addr: addr, wdata: req.payload.write_data};
    rom_cmd = '{we: 1'b0, re: 1'b0, addr: addr[ROM_ADDR_W-1:0],
                wdata: req.payload.write_data};

    if (clr_busy) begin
      ram_cmd.we    = 1'b1;
      ram_cmd.addr  = clr_addr;
      ram_cmd.wdata = clr_addr[1] ? 8'h00 : 8'hFF;
      rom_cmd.we    = (clr_addr[RAM_ADDR_W-1:ROM_ADDR_W] == '0);
      rom_cmd.addr  = clr_addr[ROM_ADDR_W-1:0];
      rom_cmd.wdata = 8'hFF;
    end else if (accept) begin
      if (req.payload.func == FUNC_LOAD) begin
        rom_cmd.we = (addr[15:14] == 2'b11);
      end else if (is_rw) begin
        if (addr[15:14] != 2'b11) begin
          ram_cmd.we = is_write;
          ram_cmd.re = !is_write;
          stage_next.src = is_write ? SRC_CONST : SRC_RAM;
        end else if (addr[15:8] == IO_PAGE) begin
          if (low >= SLOT_LOW) begin
            stage_next.slot_io = 1'b1;
          end else if (is_switch) begin
            second_bank_next    = !low[3];
            read_from_card_next = (low[1:0] == SW_READ_CARD) || (low[1:0] == SW_CARD_WE);
            if (!low[0]) begin
              card_locked_next    = 1'b1;
              prewrite_armed_next = 1'b0;
            end else begin
              // Writing opens only on the second odd access in a row.
              if (prewrite_armed) begin
                card_locked_next = 1'b0;
              end
              prewrite_armed_next = 1'b1;
            end
          end else if (low == STROBE_LOW) begin
            key_latch_next = key_latch & KEY_MASK;
            if (!is_write) begin
              stage_next.const_data = key_latch & KEY_MASK;
            end
          end else if (low == KBD_LOW) begin
            if (!is_write) begin
              if (req.payload.key_code != 7'd0) begin
                key_latch_next = STROBE_BIT | {1'b0, req.payload.key_code};
              end
              stage_next.const_data = key_latch_next;
            end
          end else if (!is_write) begin
            rom_cmd.re     = 1'b1;
            stage_next.src = SRC_ROM;
          end
        end else if (addr[15:12] != CARD_LOW && addr[15:13] != 3'b111) begin
          rom_cmd.re     = !is_write;
          stage_next.src = is_write ? SRC_CONST : SRC_ROM;
        end else if (is_write) begin
          ram_cmd.we   = !card_locked;
          ram_cmd.addr = card_addr;
        end else if (read_from_card) begin
          ram_cmd.re     = 1'b1;
          ram_cmd.addr   = card_addr;
          stage_next.src = SRC_RAM;
        end else begin
          rom_cmd.re     = 1'b1;
          stage_next.src = SRC_ROM;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_from_card  <= 1'b0;
      second_bank     <= 1'b1;
      card_locked     <= 1'b1;
      prewrite_armed  <= 1'b0;
      key_latch       <= 8'h00;
      clr_busy        <= 1'b1;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
    end else begin
      read_from_card  <= read_from_card_next;
      second_bank     <= second_bank_next;
      card_locked     <= card_locked_next;
      prewrite_armed  <= prewrite_armed_next;
      key_latch       <= key_latch_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !accept)
    else $error("transfer accepted during clearing pass");

  a_protect_switch: assert property (@(posedge clk) disable iff (rst)
    accept && is_switch && !low[0] |=> card_locked && !prewrite_armed)
    else $error("protect switch did not protect the card");

  a_unprotect_needs_arm: assert property (@(posedge clk) disable iff (rst)
    $fell(card_locked) |-> $past(prewrite_armed) && $past(accept))
    else $error("card write enabled without a prior odd access");

  a_card_write_blocked: assert property (@(posedge clk) disable iff (rst)
    !clr_busy && card_locked && ram_cmd.we |-> ram_cmd.addr[15:14] != 2'b11)
    else $error("write reached protected card RAM");
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bank_switched_memory_mapper_top: directed and random
// bus traffic with its own model of the memory map. Depends on bsmm_pkg and bsmm_chan_if.
module testbench;
  import bsmm_pkg::*;

  // Nothing is accepted during the clearing pass after reset.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TAIL_CYCLES    = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsmm_chan_if #(.payload_t(req_t)) req_if ();
  bsmm_chan_if #(.payload_t(rsp_t)) rsp_if ();

  bank_switched_memory_mapper_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #4 clk = ~clk;

  // Model of the memory map.
  logic [7:0] main_mem     [0:16'hBFFF];
  logic [7:0] rom_mem      [0:16'h3FFF];
  logic [7:0] bank_one_mem [0:16'h0FFF];
  logic [7:0] bank_two_mem [0:16'h0FFF];
  logic [7:0] high_mem     [0:16'h1FFF];
  logic       card_read_sel;
  logic       bank_two_sel;
  logic       write_lock;
  logic       write_armed;
  logic [7:0] key_reg;

  rsp_t pending_results[$];
  rsp_t want;
  int   mismatch_count = 0;
  int   items_sent = 0;
  int   stalled_cycles = 0;
  int   rsp_hold_cycles = 0;
  bit   send_gaps_on = 1'b1;
  bit   rsp_gaps_on = 1'b1;

  function automatic rsp_t predict_bus_result(req_t r);
    rsp_t       res;
    logic [7:0] low;
    logic       wr;
    res = '0;
    low = r.address[7:0];
    wr  = (r.func == FUNC_WRITE);
    case (r.func)
      FUNC_LOAD: begin
        if (r.address >= 16'hC000) rom_mem[r.address[13:0]] = r.write_data;
      end
      FUNC_READ, FUNC_WRITE: begin
        if (r.address < 16'hC000) begin
          if (wr) main_mem[r.address] = r.write_data;
          else res.read_data = main_mem[r.address];
        end else if (r.address[15:8] == IO_PAGE) begin
          if (low >= SLOT_LOW) begin
            res.slot_io = 1'b1;
          end else if (low[7:4] == SWITCH_ROW) begin
            // Bit 3 picks bank one; bit 2 is a don't-care mirror.
            bank_two_sel  = !low[3];
            card_read_sel = (low[1:0] == SW_READ_CARD) || (low[1:0] == SW_CARD_WE);
            if (!low[0]) begin
              write_lock  = 1'b1;
              write_armed = 1'b0;
            end else begin
              // Only the second odd access in a row lifts the protection.
              if (write_armed) write_lock = 1'b0;
              write_armed = 1'b1;
            end
          end else if (low == STROBE_LOW) begin
            key_reg = key_reg & KEY_MASK;
            if (!wr) res.read_data = key_reg;
          end else if (low == KBD_LOW) begin
            if (!wr) begin
              if (r.key_code != 7'd0) key_reg = {1'b1, r.key_code};
              res.read_data = key_reg;
            end
          end else if (!wr) begin
            res.read_data = rom_mem[r.address[13:0]];
          end
        end else if (r.address < 16'hD000) begin
          if (!wr) res.read_data = rom_mem[r.address[13:0]];
        end else if (wr) begin
          if (!write_lock) begin
            if (r.address >= 16'hE000) high_mem[r.address[12:0]] = r.write_data;
            else if (bank_two_sel) bank_two_mem[r.address[11:0]] = r.write_data;
            else bank_one_mem[r.address[11:0]] = r.write_data;
          end
        end else if (!card_read_sel) begin
          res.read_data = rom_mem[r.address[13:0]];
        end else if (r.address >= 16'hE000) begin
          res.read_data = high_mem[r.address[12:0]];
        end else if (bank_two_sel) begin
          res.read_data = bank_two_mem[r.address[11:0]];
        end else begin
          res.read_data = bank_one_mem[r.address[11:0]];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Responses are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected response: read_data %0h slot_io %0b",
                 rsp_if.payload.read_data, rsp_if.payload.slot_io);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.payload.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data,
                   rsp_if.payload.read_data);
            mismatch_count++;
          end
          if (rsp_if.payload.slot_io !== want.slot_io) begin
            $error("slot_io: expected %0b, actual %0b", want.slot_io,
                   rsp_if.payload.slot_io);
            mismatch_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready)
        pending_results.push_back(predict_bus_result(req_if.payload));
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("bank_switched_memory_mapper_top: mismatch");
        $finish;
      end
    end
  end

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Response side: random stalls, or one long hold-off when a test asks for it.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic req_t mk(logic [1:0] f, logic [15:0] a, logic [7:0] d, logic [6:0] k);
    req_t r;
    r.func       = f;
    r.address    = a;
    r.write_data = d;
    r.key_code   = k;
    return r;
  endfunction

  // Valid stays high from one item to the next unless a gap follows the transfer.
  task automatic send_item(req_t r);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Mostly addresses at the edges of each card region, so reads meet earlier writes; now and then any card address.
  function automatic logic [15:0] card_spot();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'hD000, 16'hD00F));
      1: return 16'($urandom_range(16'hDFF0, 16'hDFFF));
      2: return 16'($urandom_range(16'hE000, 16'hE00F));
      3: return 16'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return 16'($urandom_range(16'hD000, 16'hFFFF));
    endcase
  endfunction

  function automatic req_t random_access();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.func       = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
    r.write_data = 8'($urandom);
    r.key_code   = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0;
    if (pick < 25) begin
      r.address = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hBFFF)) :
                  16'($urandom_range(0, 2) * 16'h4000 + $urandom_range(0, 15));
    end else if (pick < 45) begin
      r.address = card_spot();
    end else if (pick < 57) begin
      r.address = 16'hC080 | 16'($urandom_range(0, 15));
    end else if (pick < 65) begin
      r.address = ($urandom_range(0, 1) == 0) ? 16'hC000 : 16'hC010;
    end else if (pick < 71) begin
      r.address = 16'($urandom_range(16'hC090, 16'hC0FF));
    end else if (pick < 78) begin
      r.address = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'hC001, 16'hC07F)) :
                  16'($urandom_range(16'hC100, 16'hCFFF));
    end else if (pick < 86) begin
      r.func    = FUNC_LOAD;
      r.address = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                  ($urandom_range(0, 1) == 0) ? card_spot() :
                  16'($urandom_range(16'hC000, 16'hFFFF));
    end else if (pick < 90) begin
      r.func    = FUNC_NOP;
      r.address = 16'($urandom);
    end else begin
      r.func    = 2'($urandom);
      r.address = 16'($urandom);
    end
    return r;
  endfunction

  // Enable writes with two odd switch accesses, write a few card bytes, switch
  // to card reads and read them back. Sometimes the arming access is single.
  task automatic run_card_session();
    logic [15:0] spots [6];
    logic [15:0] base;
    logic [1:0]  odd_mode;
    int          n;
    base     = 16'hC080 | (($urandom_range(0, 1) == 0) ? 16'h0008 : 16'h0000) |
               (($urandom_range(0, 1) == 0) ? 16'h0004 : 16'h0000);
    odd_mode = ($urandom_range(0, 1) == 0) ? SW_ROM_WE : SW_CARD_WE;
    n        = $urandom_range(2, 6);
    send_item(mk(2'($urandom_range(0, 1)), base | 16'(odd_mode), 8'($urandom), 7'd0));
    if ($urandom_range(0, 4) != 0)
      send_item(mk(2'($urandom_range(0, 1)), base | 16'(odd_mode), 8'($urandom), 7'd0));
    for (int i = 0; i < n; i++) begin
      spots[i] = card_spot();
      send_item(mk(FUNC_WRITE, spots[i], 8'($urandom), 7'd0));
    end
    if (odd_mode == SW_ROM_WE || $urandom_range(0, 3) == 0)
      send_item(mk(FUNC_READ, base | 16'(($urandom_range(0, 1) == 0) ? SW_READ_CARD : SW_CARD_WE),
                   8'd0, 7'd0));
    for (int i = 0; i < n; i++)
      send_item(mk(FUNC_READ, spots[$urandom_range(0, n - 1)], 8'd0, 7'd0));
    if ($urandom_range(0, 2) == 0) begin
      send_item(mk(FUNC_READ, base | 16'(($urandom_range(0, 1) == 0) ? SW_READ_CARD : SW_ROM_PROT),
                   8'd0, 7'd0));
      send_item(mk(FUNC_WRITE, spots[0], 8'($urandom), 7'd0));
      send_item(mk(FUNC_READ, spots[0], 8'd0, 7'd0));
    end
  endtask

  task automatic test_directed_map();
    send_item(mk(FUNC_READ,  16'h0000, 8'h00, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hBFFF, 8'hFF, 7'd0));
    send_item(mk(FUNC_READ,  16'hBFFF, 8'h00, 7'd0));
    send_item(mk(FUNC_LOAD,  16'hFFFF, 8'h00, 7'd0));
    // A ROM load below C000 is dropped, so main RAM keeps its pattern.
    send_item(mk(FUNC_LOAD,  16'h0000, 8'h5A, 7'd0));
    send_item(mk(FUNC_READ,  16'h0000, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hC000, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hC000, 8'h00, 7'h7F));
    send_item(mk(FUNC_WRITE, 16'hC000, 8'hFF, 7'h55));
    send_item(mk(FUNC_WRITE, 16'hC010, 8'hFF, 7'd0));
    send_item(mk(FUNC_READ,  16'hC010, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hC0FF, 8'h00, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hC090, 8'hFF, 7'd0));
    send_item(mk(FUNC_READ,  16'hC07F, 8'h00, 7'd0));
    send_item(mk(FUNC_NOP,   16'hFFFF, 8'hFF, 7'h7F));
  endtask

  task automatic test_directed_card();
    // First odd access only arms; the write after it must be dropped.
    send_item(mk(FUNC_READ,  16'hC08B, 8'h00, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hD000, 8'hA5, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hC08B, 8'h00, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hD000, 8'h5A, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hFFFF, 8'hA5, 7'd0));
    send_item(mk(FUNC_READ,  16'hD000, 8'h00, 7'd0));
    // Mirror of C083: bank two, card read, write stays enabled.
    send_item(mk(FUNC_READ,  16'hC087, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hD000, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hC082, 8'h00, 7'd0));
    send_item(mk(FUNC_WRITE, 16'hE000, 8'h3C, 7'd0));
    send_item(mk(FUNC_READ,  16'hFFFF, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hC080, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hFFFF, 8'h00, 7'd0));
    send_item(mk(FUNC_READ,  16'hE000, 8'h00, 7'd0));
  endtask

  task automatic test_random_traffic(int count, bit with_gaps);
    int target;
    target       = items_sent + count;
    send_gaps_on = with_gaps;
    rsp_gaps_on  = with_gaps;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) run_card_session();
      else send_item(random_access());
    end
    send_gaps_on = 1'b1;
    rsp_gaps_on  = 1'b1;
    wait_all_results();
  endtask

  // The response side holds off while requests keep coming, so the block
  // fills and stops taking transfers until the hold-off ends.
  task automatic test_back_pressure();
    send_gaps_on    = 1'b0;
    rsp_hold_cycles = 300;
    repeat (40) send_item(random_access());
    send_gaps_on = 1'b1;
    wait_all_results();
  endtask

  initial begin
    for (int i = 0; i < 16'hC000; i++) main_mem[i] = (i[1] == 1'b0) ? 8'hFF : 8'h00;
    for (int i = 0; i < 16'h4000; i++) rom_mem[i] = 8'hFF;
    for (int i = 0; i < 16'h1000; i++) begin
      bank_one_mem[i] = (i[1] == 1'b0) ? 8'hFF : 8'h00;
      bank_two_mem[i] = (i[1] == 1'b0) ? 8'hFF : 8'h00;
    end
    for (int i = 0; i < 16'h2000; i++) high_mem[i] = (i[1] == 1'b0) ? 8'hFF : 8'h00;
    card_read_sel = 1'b0;
    bank_two_sel  = 1'b1;
    write_lock    = 1'b1;
    write_armed   = 1'b0;
    key_reg       = 8'h00;

    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_map();
    test_directed_card();
    wait_all_results();
    test_random_traffic(720, 1'b1);
    test_back_pressure();
    test_random_traffic(260, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("bank_switched_memory_mapper_top: match");
    end else begin
      $display("bank_switched_memory_mapper_top: mismatch");
    end
    $finish;
  end

endmodule
